>>> rtl/psq_pkg.sv
// package: transaction types, type codes and shared helpers for the paired-single converter
`default_nettype none
package psq_pkg;

	localparam logic [2:0] TYPE_U8  = 3'd4;
	localparam logic [2:0] TYPE_U16 = 3'd5;
	localparam logic [2:0] TYPE_S8  = 3'd6;
	localparam logic [2:0] TYPE_S16 = 3'd7;

	localparam logic [63:0] DBL_ONE_BITS = 64'h3FF0_0000_0000_0000;

	localparam logic [1:0] WCNT_NONE = 2'd0;
	localparam logic [1:0] WCNT_ONE  = 2'd1;
	localparam logic [1:0] WCNT_TWO  = 2'd2;

	typedef struct packed {
		logic        action;
		logic [31:0] quant_control;
		logic        single_only;
		logic [31:0] address;
		logic [31:0] load_elem0;
		logic [31:0] load_elem1;
		logic [63:0] store_value0;
		logic [63:0] store_value1;
	} psq_in_t;

	typedef struct packed {
		logic [63:0] ps0_bits;
		logic [63:0] ps1_bits;
		logic [2:0]  elem_size;
		logic [31:0] write_addr0;
		logic [31:0] write_addr1;
		logic [31:0] write_data0;
		logic [31:0] write_data1;
		logic [1:0]  write_count;
	} psq_out_t;

	// per-stage load enables shared by the element converters
	typedef struct packed {
		logic s1;
		logic s2;
		logic s3;
	} stage_en_t;

	typedef struct packed {
		logic        store;
		logic        single;
		logic [2:0]  size;
		logic [31:0] addr0;
		logic [31:0] addr1;
	} psq_ctl_t;

	function automatic logic [2:0] type_size(input logic [2:0] t);
		logic [2:0] r;
		case (t)
			TYPE_U8, TYPE_S8:   r = 3'd1;
			TYPE_U16, TYPE_S16: r = 3'd2;
			default:            r = 3'd4;
		endcase
		return r;
	endfunction

endpackage
`default_nettype wire

>>> rtl/paired_single_quantized_load_store_top.sv
// top level: paired-single quantized load/store converter, three-stage pipeline
//
//  channel   signals                          direction  carries
//  in        in_valid / in_ready / in_item    input      one load or store transaction
//  out       out_valid / out_ready / out_item output     converted elements and addresses
//
// a result passes through the stage registers s1, s2 and s3 after the edge that accepts
// its transaction, and leaves once it is valid in s3 and out_ready is high
// one transaction per cycle is sustained while out_ready stays high; the two element
// converters, each with three register stages, run side by side
// each stage advances when it is empty or the stage after it advances, so bubbles
// close up and a stalled output still lets new transactions fill the stages behind it
// arst_n clears only the stage valid bits; payload registers are not reset
`default_nettype none
module paired_single_quantized_load_store_top
	import psq_pkg::*;
(
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     in_valid,
	output logic          in_ready,
	input  wire psq_in_t  in_item,
	output logic          out_valid,
	input  wire logic     out_ready,
	output psq_out_t      out_item
);

	stage_en_t en;
	logic      v_s1, v_s2, v_s3;
	psq_ctl_t  ctl_d, ctl_s1, ctl_s2, ctl_s3;
	logic [2:0]  typ;
	logic [5:0]  scale;
	logic [63:0] dbl0, dbl1;
	logic [31:0] wd0, wd1;

	// stall chain: a stage loads when it is empty or its successor moves on
	always_comb begin
		en.s3 = !v_s3 || out_ready;
		en.s2 = !v_s2 || en.s3;
		en.s1 = !v_s1 || en.s2;
	end

	assign in_ready  = en.s1;
	assign out_valid = v_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (en.s1)
				v_s1 <= in_valid;
			if (en.s2)
				v_s2 <= v_s1;
			if (en.s3)
				v_s3 <= v_s2;
		end
	end

	// type and scale come from the store half or the load half of the control word
	always_comb begin
		typ   = in_item.action ? in_item.quant_control[2:0]  : in_item.quant_control[18:16];
		scale = in_item.action ? in_item.quant_control[13:8] : in_item.quant_control[29:24];
		ctl_d.store  = in_item.action;
		ctl_d.single = in_item.single_only;
		ctl_d.size   = type_size(typ);
		ctl_d.addr0  = in_item.address;
		ctl_d.addr1  = in_item.address + {29'd0, ctl_d.size};
	end

	// transaction control rides alongside the converters
	always_ff @(posedge clk) begin
		if (en.s1)
			ctl_s1 <= ctl_d;
		if (en.s2)
			ctl_s2 <= ctl_s1;
		if (en.s3)
			ctl_s3 <= ctl_s2;
	end

	psq_elem_cvt u_elem0 (
		.clk   (clk),
		.en    (en),
		.store (in_item.action),
		.typ   (typ),
		.scale (scale),
		.raw   (in_item.load_elem0),
		.val   (in_item.store_value0),
		.dbl   (dbl0),
		.wdat  (wd0)
	);

	psq_elem_cvt u_elem1 (
		.clk   (clk),
		.en    (en),
		.store (in_item.action),
		.typ   (typ),
		.scale (scale),
		.raw   (in_item.load_elem1),
		.val   (in_item.store_value1),
		.dbl   (dbl1),
		.wdat  (wd1)
	);

	// result fields: loads fill the register values, stores the write side
	always_comb begin
		out_item = '0;
		out_item.elem_size = ctl_s3.size;
		if (!ctl_s3.store) begin
			out_item.ps0_bits = dbl0;
			out_item.ps1_bits = ctl_s3.single ? DBL_ONE_BITS : dbl1;
			out_item.write_count = WCNT_NONE;
		end else begin
			out_item.write_addr0 = ctl_s3.addr0;
			out_item.write_data0 = wd0;
			if (ctl_s3.single) begin
				out_item.write_count = WCNT_ONE;
			end else begin
				out_item.write_addr1 = ctl_s3.addr1;
				out_item.write_data1 = wd1;
				out_item.write_count = WCNT_TWO;
			end
		end
	end

	// a stalled result keeps its control fields
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		v_s3 && !out_ready |=> v_s3 && $stable(ctl_s3))
		else $error("output stage changed while stalled");

	// with every stage full and the output stalled nothing more is taken
	a_full_block: assert property (@(posedge clk) disable iff (!arst_n)
		v_s1 && v_s2 && v_s3 && !out_ready |-> !in_ready)
		else $error("input accepted into a full pipeline");

	// an accepted transaction always lands in the first stage
	a_enter: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> v_s1)
		else $error("accepted transaction lost at entry");

	// a transaction in the middle stage moves on whenever the output drains
	a_advance: assert property (@(posedge clk) disable iff (!arst_n)
		v_s2 && out_ready |=> v_s3)
		else $error("middle stage did not advance");

endmodule
`default_nettype wire

>>> rtl/psq_elem_cvt.sv
// one element converter: decode, normalize/shift, round and pack over three stages
`default_nettype none
module psq_elem_cvt
	import psq_pkg::*;
(
	input  wire logic        clk,
	input  wire stage_en_t   en,
	input  wire logic        store,
	input  wire logic [2:0]  typ,
	input  wire logic [5:0]  scale,
	input  wire logic [31:0] raw,
	input  wire logic [63:0] val,
	output logic [63:0]      dbl,
	output logic [31:0]      wdat
);

	// stage 1 decode
	logic               is_int;
	logic               wide;
	logic               neg;
	logic [15:0]        v16;
	logic [15:0]        sx;
	logic [15:0]        mag;
	logic signed [13:0] sc14;
	logic [10:0]        de;
	logic [7:0]         fe8;
	logic signed [13:0] ex_d;
	logic [52:0]        man_d;
	logic               sgn_d, nan_d, inf_d, ez_d;

	logic               st_s1, int_s1, sgn_s1, nan_s1, inf_s1, ez_s1;
	logic [2:0]         typ_s1;
	logic signed [13:0] ex_s1;
	logic [52:0]        man_s1;

	always_comb begin
		is_int = typ[2];
		wide   = typ[0];
		sc14   = {{8{scale[5]}}, scale};
		v16    = wide ? raw[15:0] : {8'd0, raw[7:0]};
		sx     = wide ? raw[15:0] : {{8{raw[7]}}, raw[7:0]};
		neg    = typ[1] & (wide ? raw[15] : raw[7]);
		mag    = neg ? (16'd0 - sx) : v16;
		de     = val[62:52];
		fe8    = raw[30:23];
		sgn_d  = 1'b0;
		nan_d  = 1'b0;
		inf_d  = 1'b0;
		ez_d   = 1'b0;
		ex_d   = '0;
		man_d  = '0;
		if (store) begin
			sgn_d = val[63];
			nan_d = (de == 11'h7FF) && (val[51:0] != '0);
			inf_d = (de == 11'h7FF) && (val[51:0] == '0);
			ez_d  = (de == 11'd0);
			man_d = {1'b1, val[51:0]};
			if (is_int)
				ex_d = $signed({3'd0, de}) - 14'sd1023 + sc14;
			else
				ex_d = $signed({3'd0, de}) - 14'sd896;
		end else if (is_int) begin
			sgn_d = neg;
			ex_d  = 14'sd1023 - sc14;
			man_d = {37'd0, mag};
		end else begin
			sgn_d = raw[31];
			nan_d = (fe8 == 8'hFF) && (raw[22:0] != '0);
			inf_d = (fe8 == 8'hFF) && (raw[22:0] == '0);
			ez_d  = (fe8 == 8'd0);
			ex_d  = $signed({6'd0, fe8});
			man_d = {30'd0, raw[22:0]};
		end
	end

	always_ff @(posedge clk) begin
		if (en.s1) begin
			st_s1  <= store;
			int_s1 <= is_int;
			typ_s1 <= typ;
			sgn_s1 <= sgn_d;
			nan_s1 <= nan_d;
			inf_s1 <= inf_d;
			ez_s1  <= ez_d;
			ex_s1  <= ex_d;
			man_s1 <= man_d;
		end
	end

	// stage 2: leading-one search for loads, alignment shift for stores
	logic [4:0]  p;
	logic [22:0] lfrac;
	logic [5:0]  sa;
	logic [15:0] ival;
	logic        isat, izero;
	logic        big, tiny;
	logic signed [13:0] shw;
	logic [5:0]  sh, shm1;
	logic [53:0] g, mask;
	logic [23:0] keep;
	logic        rnd;
	logic [22:0] pl;

	logic               st_s2, int_s2, sgn_s2, nan_s2, inf_s2, ez_s2;
	logic               isat_s2, izero_s2, big_s2, tiny_s2, rnd_s2, lzero_s2;
	logic [2:0]         typ_s2;
	logic signed [13:0] ex_s2;
	logic [4:0]         p_s2;
	logic [22:0]        lfrac_s2, pl_s2;
	logic [15:0]        ival_s2;
	logic [23:0]        keep_s2;

	always_comb begin
		p = '0;
		for (int i = 0; i < 23; i++) begin
			if (man_s1[i])
				p = 5'(i);
		end
		lfrac = 23'(man_s1[22:0] << (5'd23 - p));
		pl    = st_s1 ? man_s1[51:29] : man_s1[22:0];

		// integer store: whole part of the scaled magnitude
		isat  = (ex_s1 > 14'sd15) || inf_s1;
		izero = ez_s1 || (ex_s1 < 14'sd0);
		sa    = 6'd52 - 6'(ex_s1);
		ival  = 16'(man_s1 >> sa);

		// float store: narrow with round to nearest even
		big  = ex_s1 >= 14'sd255;
		tiny = ex_s1 < -14'sd24;
		shw  = (ex_s1 >= 14'sd1) ? 14'sd29 : (14'sd30 - ex_s1);
		sh   = 6'(shw);
		shm1 = sh - 6'd1;
		g    = {1'b0, man_s1} >> shm1;
		mask = (54'd1 << shm1) - 54'd1;
		keep = g[24:1];
		rnd  = g[0] & ((|({1'b0, man_s1} & mask)) | g[1]);
	end

	always_ff @(posedge clk) begin
		if (en.s2) begin
			st_s2    <= st_s1;
			int_s2   <= int_s1;
			typ_s2   <= typ_s1;
			sgn_s2   <= sgn_s1;
			nan_s2   <= nan_s1;
			inf_s2   <= inf_s1;
			ez_s2    <= ez_s1;
			ex_s2    <= ex_s1;
			p_s2     <= p;
			lfrac_s2 <= lfrac;
			lzero_s2 <= (man_s1[22:0] == '0);
			pl_s2    <= pl;
			ival_s2  <= ival;
			isat_s2  <= isat;
			izero_s2 <= izero;
			big_s2   <= big;
			tiny_s2  <= tiny;
			keep_s2  <= keep;
			rnd_s2   <= rnd;
		end
	end

	// stage 3: exponent, clamp, round increment and packing
	logic [63:0]        dbl_d;
	logic [31:0]        wd_d;
	logic [13:0]        lexp;
	logic [15:0]        imag, ilim, iclip;
	logic [24:0]        keep2;
	logic signed [13:0] fe2;

	always_comb begin
		dbl_d = '0;
		wd_d  = '0;
		lexp  = '0;
		imag  = '0;
		ilim  = '0;
		iclip = '0;
		keep2 = {1'b0, keep_s2} + 25'(rnd_s2);
		fe2   = ex_s2;
		if (!st_s2) begin
			if (int_s2) begin
				lexp = 14'(ex_s2) + 14'(p_s2);
				if (!lzero_s2)
					dbl_d = {sgn_s2, lexp[10:0], lfrac_s2, 29'd0};
			end else if (nan_s2) begin
				dbl_d = {sgn_s2, 11'h7FF, 1'b1, pl_s2[21:0], 29'd0};
			end else if (inf_s2) begin
				dbl_d = {sgn_s2, 11'h7FF, 52'd0};
			end else if (ez_s2) begin
				lexp = 14'd874 + 14'(p_s2);
				if (lzero_s2)
					dbl_d = {sgn_s2, 63'd0};
				else
					dbl_d = {sgn_s2, lexp[10:0], lfrac_s2, 29'd0};
			end else begin
				lexp  = 14'(ex_s2) + 14'd896;
				dbl_d = {sgn_s2, lexp[10:0], pl_s2, 29'd0};
			end
		end else if (int_s2) begin
			imag = isat_s2 ? 16'hFFFF : (izero_s2 ? 16'd0 : ival_s2);
			case (typ_s2)
				TYPE_U8:  ilim = 16'd255;
				TYPE_U16: ilim = 16'd65535;
				TYPE_S8:  ilim = sgn_s2 ? 16'd128 : 16'd127;
				default:  ilim = sgn_s2 ? 16'd32768 : 16'd32767;
			endcase
			iclip = (imag > ilim) ? ilim : imag;
			if (nan_s2 || (sgn_s2 && !typ_s2[1]))
				wd_d = '0;
			else if (sgn_s2)
				wd_d = typ_s2[0] ? {16'd0, 16'd0 - iclip} : {24'd0, 8'd0 - iclip[7:0]};
			else
				wd_d = {16'd0, iclip};
		end else begin
			if (nan_s2)
				wd_d = {sgn_s2, 31'h7FC0_0000 | {8'd0, pl_s2}};
			else if (inf_s2)
				wd_d = {sgn_s2, 31'h7F80_0000};
			else if (ez_s2 || tiny_s2)
				wd_d = {sgn_s2, 31'd0};
			else if (big_s2)
				wd_d = {sgn_s2, 31'h7F80_0000};
			else if (ex_s2 < 14'sd1)
				wd_d = {sgn_s2, 6'd0, keep2};
			else begin
				if (keep2[24])
					fe2 = ex_s2 + 14'sd1;
				if (fe2 >= 14'sd255)
					wd_d = {sgn_s2, 31'h7F80_0000};
				else
					wd_d = {sgn_s2, fe2[7:0], keep2[24] ? 23'd0 : keep2[22:0]};
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en.s3) begin
			dbl  <= dbl_d;
			wdat <= wd_d;
		end
	end

endmodule
`default_nettype wire

>>> tb/sv/paired_single_quantized_load_store_top_tb.sv
// testbench for the paired-single quantized load/store converter: directed table plus random traffic
`default_nettype none
module paired_single_quantized_load_store_top_tb;
	import psq_pkg::*;

	localparam int PERIOD_HALF = 10;
	localparam int RANDOM_ITEMS = 1250;
	localparam int WATCHDOG_LIMIT = 20000;
	localparam int DRAIN_CYCLES = 10;
	localparam int LONG_HOLD = 60;

	localparam logic ACT_LOAD  = 1'b0;
	localparam logic ACT_STORE = 1'b1;
	localparam logic [2:0] TYPE_FLOAT = 3'd0;

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_ready;
	psq_in_t in_item;
	logic out_valid;
	logic out_ready;
	psq_out_t out_item;

	paired_single_quantized_load_store_top u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_item  (in_item),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_item (out_item)
	);

	// free-running clock, 20 time units per period
	initial clk = 1'b0;
	always begin
		#PERIOD_HALF clk = 1'b1;
		#PERIOD_HALF clk = 1'b0;
	end

	// ---------------------------------------------------------------- predictor
	// signed 6-bit scale field
	function automatic int scale_of(input logic [5:0] s6);
		return s6[5] ? int'(s6) - 64 : int'(s6);
	endfunction

	function automatic real pow2_exact(input int e);
		return $bitstoreal({1'b0, 11'(1023 + e), 52'd0});
	endfunction

	function automatic logic [63:0] widen_float(input logic [31:0] b);
		logic [63:0] sgn;
		logic [7:0] e;
		logic [22:0] m;
		int k;
		sgn = {b[31], 63'd0};
		e = b[30:23];
		m = b[22:0];
		k = 0;
		if (e == 8'hFF) begin
			if (m == 0)
				return sgn | {1'b0, 11'h7FF, 52'd0};
			return sgn | {1'b0, 11'h7FF, 1'b1, m[21:0], 29'd0};
		end
		if (e == 0) begin
			if (m == 0)
				return sgn;
			while (m[22] == 1'b0) begin
				m = m << 1;
				k++;
			end
			// leading one drops out as the hidden bit
			m = m << 1;
			k++;
			return sgn | {1'b0, 11'(1023 - 127 - k + 1), m, 29'd0};
		end
		return sgn | {1'b0, 11'(int'(e) - 127 + 1023), m, 29'd0};
	endfunction

	function automatic logic [31:0] narrow_double(input logic [63:0] b);
		logic [31:0] sgn;
		int e, fe, sh;
		logic [63:0] full, keep, rem, half;
		sgn = {b[63], 31'd0};
		e = int'(b[62:52]);
		if (e == 'h7FF) begin
			if (b[51:0] == 0)
				return sgn | 32'h7F80_0000;
			return sgn | 32'h7FC0_0000 | 32'(b[51:29]);
		end
		if (e == 0)
			return sgn;
		full = {11'd1, b[51:0]};
		fe = e - 1023 + 127;
		if (fe >= 255)
			return sgn | 32'h7F80_0000;
		sh = (fe >= 1) ? 29 : 30 - fe;
		if (sh > 54)
			return sgn;
		keep = full >> sh;
		rem = full & ((64'd1 << sh) - 64'd1);
		half = 64'd1 << (sh - 1);
		if (rem > half || (rem == half && keep[0]))
			keep++;
		if (fe < 1)
			return sgn | keep[31:0];
		if (keep == (64'd1 << 24)) begin
			keep = keep >> 1;
			fe++;
		end
		if (fe >= 255)
			return sgn | 32'h7F80_0000;
		return sgn | {1'b0, 8'(fe), keep[22:0]};
	endfunction

	function automatic logic [63:0] dequantize(input logic [2:0] t, input int sc,
			input logic [31:0] raw);
		real v;
		case (t)
			TYPE_U8:  v = real'(int'(raw[7:0]));
			TYPE_U16: v = real'(int'(raw[15:0]));
			TYPE_S8:  v = real'(int'($signed(raw[7:0])));
			TYPE_S16: v = real'(int'($signed(raw[15:0])));
			default:  return widen_float(raw);
		endcase
		return $realtobits(v * pow2_exact(-sc));
	endfunction

	function automatic logic [31:0] quantize(input logic [2:0] t, input int sc,
			input logic [63:0] vb);
		real x, lo, hi;
		if (t < TYPE_U8)
			return narrow_double(vb);
		// nan detection on the bits, before scaling
		if (vb[62:52] == 11'h7FF && vb[51:0] != 0)
			return 32'd0;
		x = $bitstoreal(vb) * pow2_exact(sc);
		case (t)
			TYPE_U8:  begin lo = 0.0;      hi = 255.0;   end
			TYPE_U16: begin lo = 0.0;      hi = 65535.0; end
			TYPE_S8:  begin lo = -128.0;   hi = 127.0;   end
			default:  begin lo = -32768.0; hi = 32767.0; end
		endcase
		if (x < lo) x = lo;
		if (x > hi) x = hi;
		// truncation toward zero; $rtoi does that
		case (t)
			TYPE_S8:  return {24'd0, 8'($rtoi(x))};
			TYPE_S16: return {16'd0, 16'($rtoi(x))};
			default:  return 32'($rtoi(x));
		endcase
	endfunction

	function automatic psq_out_t convert(input psq_in_t it);
		psq_out_t r;
		logic [2:0] t;
		r = '0;
		if (it.action == ACT_LOAD) begin
			t = it.quant_control[18:16];
			r.ps0_bits = dequantize(t, scale_of(it.quant_control[29:24]), it.load_elem0);
			r.ps1_bits = it.single_only ? DBL_ONE_BITS
				: dequantize(t, scale_of(it.quant_control[29:24]), it.load_elem1);
			r.elem_size = type_size(t);
		end else begin
			t = it.quant_control[2:0];
			r.elem_size = type_size(t);
			r.write_addr0 = it.address;
			r.write_data0 = quantize(t, scale_of(it.quant_control[13:8]), it.store_value0);
			if (it.single_only) begin
				r.write_count = WCNT_ONE;
			end else begin
				r.write_addr1 = it.address + 32'(r.elem_size);
				r.write_data1 = quantize(t, scale_of(it.quant_control[13:8]),
					it.store_value1);
				r.write_count = WCNT_TWO;
			end
		end
		return r;
	endfunction

	// ---------------------------------------------------------------- scoreboard
	psq_out_t expected_results[$];
	int fail_count = 0;
	int idle_cycles = 0;

	// idling knobs, percent of cycles
	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	bit hold_recv = 1'b0;

	task automatic compare_result(input psq_out_t exp_r, input psq_out_t act);
		if (act.ps0_bits !== exp_r.ps0_bits) begin
			$error("ps0_bits expected %h actual %h", exp_r.ps0_bits, act.ps0_bits);
			fail_count++;
		end
		if (act.ps1_bits !== exp_r.ps1_bits) begin
			$error("ps1_bits expected %h actual %h", exp_r.ps1_bits, act.ps1_bits);
			fail_count++;
		end
		if (act.elem_size !== exp_r.elem_size) begin
			$error("elem_size expected %0d actual %0d", exp_r.elem_size, act.elem_size);
			fail_count++;
		end
		if (act.write_addr0 !== exp_r.write_addr0) begin
			$error("write_addr0 expected %h actual %h", exp_r.write_addr0, act.write_addr0);
			fail_count++;
		end
		if (act.write_addr1 !== exp_r.write_addr1) begin
			$error("write_addr1 expected %h actual %h", exp_r.write_addr1, act.write_addr1);
			fail_count++;
		end
		if (act.write_data0 !== exp_r.write_data0) begin
			$error("write_data0 expected %h actual %h", exp_r.write_data0, act.write_data0);
			fail_count++;
		end
		if (act.write_data1 !== exp_r.write_data1) begin
			$error("write_data1 expected %h actual %h", exp_r.write_data1, act.write_data1);
			fail_count++;
		end
		if (act.write_count !== exp_r.write_count) begin
			$error("write_count expected %0d actual %0d", exp_r.write_count, act.write_count);
			fail_count++;
		end
	endtask

	// output monitor and receiver; decisions made at the edge, after sampling
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && out_ready) begin
				if (expected_results.size() == 0) begin
					$error("result transaction with nothing expected");
					fail_count++;
				end else begin
					compare_result(expected_results.pop_front(), out_item);
				end
			end
			if (hold_recv)
				out_ready <= 1'b0;
			else
				out_ready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	// watchdog: cycles without any handshake on the input or the output
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("end of test: mismatches");
				$finish;
			end
		end
	end

	// ---------------------------------------------------------------- stimulus
	typedef struct {
		psq_in_t item;
		bit has_fixed;
		psq_out_t fixed;
	} stim_row_t;

	stim_row_t directed[$];

	function automatic psq_in_t make_item(input logic act, input logic [2:0] ltype,
			input logic [5:0] lsc, input logic [2:0] stype, input logic [5:0] ssc,
			input logic single, input logic [31:0] addr, input logic [31:0] e0,
			input logic [31:0] e1, input logic [63:0] v0, input logic [63:0] v1);
		psq_in_t it;
		it = '0;
		it.action = act;
		it.quant_control = {2'b00, lsc, 5'd0, ltype, 2'b00, ssc, 5'd0, stype};
		it.single_only = single;
		it.address = addr;
		it.load_elem0 = e0;
		it.load_elem1 = e1;
		it.store_value0 = v0;
		it.store_value1 = v1;
		return it;
	endfunction

	function automatic psq_out_t load_out(input logic [63:0] p0, input logic [63:0] p1,
			input logic [2:0] sz);
		psq_out_t r;
		r = '0;
		r.ps0_bits = p0;
		r.ps1_bits = p1;
		r.elem_size = sz;
		return r;
	endfunction

	function automatic psq_out_t store_out(input logic [2:0] sz, input logic [31:0] a0,
			input logic [31:0] a1, input logic [31:0] d0, input logic [31:0] d1,
			input logic [1:0] cnt);
		psq_out_t r;
		r = '0;
		r.elem_size = sz;
		r.write_addr0 = a0;
		r.write_addr1 = a1;
		r.write_data0 = d0;
		r.write_data1 = d1;
		r.write_count = cnt;
		return r;
	endfunction

	task automatic add_row(input psq_in_t it, input bit fixed_valid, input psq_out_t fx);
		stim_row_t row;
		row.item = it;
		row.has_fixed = fixed_valid;
		row.fixed = fx;
		directed.push_back(row);
	endtask

	task automatic build_directed();
		// u8 load extremes at scale zero
		add_row(make_item(ACT_LOAD, TYPE_U8, 6'd0, 3'd0, 6'd0, 1'b0, 32'd0,
			32'h0000_00FF, 32'h0000_0000, 64'd0, 64'd0), 1'b1,
			load_out(64'h406F_E000_0000_0000, 64'd0, 3'd1));
		// s8 extremes, single load gives 1.0 for the second element
		add_row(make_item(ACT_LOAD, TYPE_S8, 6'd0, 3'd0, 6'd0, 1'b1, 32'd0,
			32'hFFFF_FF80, 32'h1234_5678, 64'd0, 64'd0), 1'b1,
			load_out(64'hC060_0000_0000_0000, DBL_ONE_BITS, 3'd1));
		add_row(make_item(ACT_LOAD, TYPE_U16, 6'h20, 3'd0, 6'd0, 1'b0, 32'd0,
			32'hFFFF_FFFF, 32'h0000_0001, 64'd0, 64'd0), 1'b0, '0);
		add_row(make_item(ACT_LOAD, TYPE_S16, 6'h1F, 3'd0, 6'd0, 1'b0, 32'd0,
			32'h0000_8000, 32'h0000_7FFF, 64'd0, 64'd0), 1'b0, '0);
		// float loads: infinity, nan, subnormal; scale ignored
		add_row(make_item(ACT_LOAD, TYPE_FLOAT, 6'h3F, 3'd0, 6'd0, 1'b0, 32'd0,
			32'h7F80_0000, 32'hFF80_0001, 64'd0, 64'd0), 1'b1,
			load_out(64'h7FF0_0000_0000_0000, 64'hFFF8_0000_2000_0000, 3'd4));
		add_row(make_item(ACT_LOAD, 3'd3, 6'd5, 3'd0, 6'd0, 1'b0, 32'd0,
			32'h0000_0001, 32'h807F_FFFF, 64'd0, 64'd0), 1'b0, '0);
		// u8 store clamps: 300 saturates high, -1 low, address wraps
		add_row(make_item(ACT_STORE, 3'd0, 6'd0, TYPE_U8, 6'd0, 1'b0, 32'hFFFF_FFFF,
			32'd0, 32'd0, 64'h4072_C000_0000_0000, 64'hBFF0_0000_0000_0000), 1'b1,
			store_out(3'd1, 32'hFFFF_FFFF, 32'h0000_0000, 32'h0000_00FF, 32'd0, WCNT_TWO));
		// s8 store: nan gives 0, -infinity saturates, single store
		add_row(make_item(ACT_STORE, 3'd0, 6'd0, TYPE_S8, 6'd0, 1'b1, 32'h0000_1000,
			32'd0, 32'd0, 64'h7FF8_0000_0000_0000, 64'hFFF0_0000_0000_0000), 1'b1,
			store_out(3'd1, 32'h0000_1000, 32'd0, 32'd0, 32'd0, WCNT_ONE));
		add_row(make_item(ACT_STORE, 3'd0, 6'd0, TYPE_S8, 6'd0, 1'b0, 32'h0000_1000,
			32'd0, 32'd0, 64'hFFF0_0000_0000_0000, 64'h7FF0_0000_0000_0000), 1'b1,
			store_out(3'd1, 32'h0000_1000, 32'h0000_1001, 32'h0000_0080, 32'h0000_007F,
			WCNT_TWO));
		add_row(make_item(ACT_STORE, 3'd0, 6'd0, TYPE_U16, 6'h1F, 1'b0, 32'h8000_0000,
			32'd0, 32'd0, 64'h3FF8_0000_0000_0000, 64'h4000_0000_0000_0000), 1'b0, '0);
		add_row(make_item(ACT_STORE, 3'd0, 6'd0, TYPE_S16, 6'h20, 1'b0, 32'h0000_0010,
			32'd0, 32'd0, 64'hC0E0_0000_0000_0000, 64'h40E0_0000_0000_0000), 1'b0, '0);
		// truncation toward zero of -2.5
		add_row(make_item(ACT_STORE, 3'd0, 6'd0, TYPE_S16, 6'd0, 1'b1, 32'h0000_0020,
			32'd0, 32'd0, 64'hC004_0000_0000_0000, 64'd0), 1'b1,
			store_out(3'd2, 32'h0000_0020, 32'd0, 32'h0000_FFFE, 32'd0, WCNT_ONE));
		// float store: overflow to infinity, nan keeps payload
		add_row(make_item(ACT_STORE, 3'd0, 6'd0, TYPE_FLOAT, 6'h3F, 1'b0, 32'h0000_0100,
			32'd0, 32'd0, 64'h47F0_0000_0000_0000, 64'hFFF0_0000_2000_0001), 1'b1,
			store_out(3'd4, 32'h0000_0100, 32'h0000_0104, 32'h7F80_0000, 32'hFFC0_0001,
			WCNT_TWO));
		// float store: subnormal, underflow, ties to even
		add_row(make_item(ACT_STORE, 3'd0, 6'd0, 3'd2, 6'd0, 1'b0, 32'h0000_0200,
			32'd0, 32'd0, 64'h3800_0000_0000_0000, 64'h0000_0000_0000_0001), 1'b0, '0);
		add_row(make_item(ACT_STORE, 3'd0, 6'd0, 3'd1, 6'd0, 1'b0, 32'h0000_0200,
			32'd0, 32'd0, 64'h3FF0_0000_1000_0000, 64'h3FF0_0000_3000_0000), 1'b0, '0);
		add_row(make_item(ACT_STORE, 3'd0, 6'd0, 3'd3, 6'd0, 1'b1, 32'h0000_0200,
			32'd0, 32'd0, 64'h47EF_FFFF_F000_0000, 64'd0), 1'b0, '0);
	endtask

	// random double with interesting exponents
	function automatic logic [63:0] rand_double();
		logic [63:0] v;
		v = {$urandom, $urandom};
		case ($urandom_range(7))
			0: v[62:52] = 11'h7FF;
			1: v[62:52] = 11'h000;
			2: v[62:52] = 11'(1023 + 127 - 2 + $urandom_range(4));
			3: v[62:52] = 11'(1023 - 150 + $urandom_range(30));
			4: v[62:52] = 11'(1023 - 20 + $urandom_range(40));
			default: ;
		endcase
		if ($urandom_range(9) == 0)
			v[28:0] = ($urandom_range(1) != 0) ? 29'h1000_0000 : 29'd0;
		return v;
	endfunction

	function automatic psq_in_t rand_item();
		psq_in_t it;
		it.action = 1'($urandom_range(1));
		it.quant_control = $urandom;
		it.single_only = 1'($urandom_range(1));
		it.address = $urandom;
		it.load_elem0 = $urandom;
		it.load_elem1 = $urandom;
		it.store_value0 = rand_double();
		it.store_value1 = rand_double();
		return it;
	endfunction

	// presents one transaction; valid stays high until accepted, and drops only
	// when the sender idles, so back-to-back transactions keep it high
	task automatic send_item(input psq_in_t it, input psq_out_t exp_r);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_item <= it;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		expected_results.push_back(exp_r);
	endtask

	// sender goes idle until every expected result has come
	task automatic wait_drained();
		in_valid <= 1'b0;
		@(posedge clk);
		while (expected_results.size() != 0)
			@(posedge clk);
	endtask

	initial begin
		psq_in_t it;
		int phase;
		int ri;
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_item = '0;
		out_ready = 1'b0;
		build_directed();
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed table: fixed rows checked against typed values, others against the predictor
		foreach (directed[i]) begin
			if (directed[i].has_fixed) begin
				if (convert(directed[i].item) !== directed[i].fixed) begin
					$error("predictor disagrees with table row %0d", i);
					fail_count++;
				end
				send_item(directed[i].item, directed[i].fixed);
			end else begin
				send_item(directed[i].item, convert(directed[i].item));
			end
		end

		// sender pause until every expected result has come
		wait_drained();

		// long receiver hold while the sender keeps offering, so the pipe fills
		hold_recv = 1'b1;
		fork
			begin
				repeat (LONG_HOLD) @(posedge clk);
				hold_recv = 1'b0;
			end
			begin
				repeat (20) begin
					it = rand_item();
					send_item(it, convert(it));
				end
				wait_drained();
			end
		join

		// random phases over the idling mixes
		for (phase = 0; phase < 5; phase++) begin
			case (phase)
				0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
				1: begin send_idle_pct = 67; recv_stall_pct = 0;  end
				2: begin send_idle_pct = 0;  recv_stall_pct = 67; end
				3: begin send_idle_pct = 27; recv_stall_pct = 27; end
				default: begin send_idle_pct = 0; recv_stall_pct = 0; end
			endcase
			for (ri = 0; ri < RANDOM_ITEMS / 5; ri++) begin
				it = rand_item();
				send_item(it, convert(it));
			end
		end
		recv_stall_pct = 0;
		wait_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fail_count == 0 && expected_results.size() == 0) begin
			$display("end of test: clean");
		end else begin
			$display("end of test: mismatches");
		end
		$finish;
	end

endmodule
`default_nettype wire

>>> paired_single_quantized_load_store_top.f
rtl/psq_pkg.sv
rtl/psq_elem_cvt.sv
rtl/paired_single_quantized_load_store_top.sv
tb/sv/paired_single_quantized_load_store_top_tb.sv
